@@ hdl/u8u2_pkg.sv @@
// shared types and constants for the utf-8 to ucs-2 stream decoder
// no dependencies; used by every module of the block
package u8u2_pkg;

    localparam logic [7:0] LEAD_ONE_LIMIT   = 8'h80;
    localparam logic [7:0] LEAD_TWO_LIMIT   = 8'hE0;
    localparam logic [7:0] LEAD_THREE_LIMIT = 8'hF0;
    localparam logic [7:0] MASK_TWO         = 8'h1F;
    localparam logic [7:0] MASK_THREE       = 8'h0F;
    localparam logic [7:0] MASK_FOUR        = 8'h07;
    localparam int         CONT_BITS        = 6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic        bad_sequence;
        logic        string_end;
    } result_t;

endpackage

@@ hdl/u8u2_in_stage.sv @@
// input register of the decoder: holds one accepted byte transfer
// depends on u8u2_pkg
module u8u2_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  u8u2_pkg::in_item_t in_item,
    input  logic               advance,
    output logic               held_valid,
    output u8u2_pkg::in_item_t held_item
);

    logic               valid_reg;
    logic               valid_next;
    u8u2_pkg::in_item_t item_reg;

    // free when empty or when the held byte moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ hdl/u8u2_decode.sv @@
// sequence state and single-pass decode of one byte into at most one result
// depends on u8u2_pkg
module u8u2_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               take,
    input  u8u2_pkg::in_item_t item,
    output logic               res_valid,
    output u8u2_pkg::result_t  res
);

    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic [15:0] partial_reg;
    logic [15:0] partial_next;
    logic [1:0]  pend_calc;
    logic [15:0] value_calc;
    logic        done;
    logic [7:0]  b;

    assign b = item.in_byte;

    always_comb begin
        done       = 1'b0;
        pend_calc  = pending_reg;
        value_calc = partial_reg;
        if (pending_reg == 2'd0) begin
            if (b < u8u2_pkg::LEAD_ONE_LIMIT) begin
                value_calc = {8'd0, b};
                done       = 1'b1;
            end else if (b < u8u2_pkg::LEAD_TWO_LIMIT) begin
                value_calc = {8'd0, b & u8u2_pkg::MASK_TWO};
                pend_calc  = 2'd1;
            end else if (b < u8u2_pkg::LEAD_THREE_LIMIT) begin
                value_calc = {8'd0, b & u8u2_pkg::MASK_THREE};
                pend_calc  = 2'd2;
            end else begin
                value_calc = {8'd0, b & u8u2_pkg::MASK_FOUR};
                pend_calc  = 2'd3;
            end
        end else begin
            // continuation: top bits of the byte are not checked
            value_calc = {partial_reg[15-u8u2_pkg::CONT_BITS:0],
                          b[u8u2_pkg::CONT_BITS-1:0]};
            pend_calc  = pending_reg - 2'd1;
            done       = (pending_reg == 2'd1);
        end

        res_valid = done || item.is_final;
        if (done) begin
            res.code_point   = value_calc;
            res.bad_sequence = 1'b0;
            res.string_end   = item.is_final;
        end else begin
            // string ended mid-sequence, partial character dropped
            res.code_point   = 16'd0;
            res.bad_sequence = 1'b1;
            res.string_end   = 1'b1;
        end

        if (res_valid) begin
            pending_next = 2'd0;
            partial_next = 16'd0;
        end else begin
            pending_next = pend_calc;
            partial_next = value_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            partial_reg <= 16'd0;
        end else if (take) begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

@@ hdl/u8u2_out_stage.sv @@
// result register of the decoder, drives the master-side transfer
// depends on u8u2_pkg
module u8u2_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              load_valid,
    input  u8u2_pkg::result_t load_res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output u8u2_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    u8u2_pkg::result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? load_valid : (free ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ hdl/utf8_to_ucs2_stream_decoder.sv @@
// top level of the utf-8 to ucs-2 stream decoder
// path: a byte is held in the input register, then its result in the result register
// throughput: one byte per cycle unless m_tready stalls; a decode is a single compare/shift/mask pass
// a byte that leaves a sequence open gives no result transfer
// reset: synchronous active-low aresetn empties both registers and clears sequence state
// depends on u8u2_pkg, u8u2_in_stage, u8u2_decode, u8u2_out_stage
module utf8_to_ucs2_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_point
    output logic        m_tuser,   // [0] bad_sequence
    output logic        m_tlast    // string_end
);

    u8u2_pkg::in_item_t in_item;
    u8u2_pkg::in_item_t held_item;
    u8u2_pkg::result_t  dec_res;
    u8u2_pkg::result_t  out_res;
    logic               held_valid;
    logic               dec_valid;
    logic               out_free;
    logic               advance;

    assign in_item.in_byte  = s_tdata;
    assign in_item.is_final = s_tlast;

    // held byte moves on whenever the result register can take its result
    assign advance = held_valid && out_free;

    u8u2_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    u8u2_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (advance),
        .item      (held_item),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    u8u2_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .load_valid (dec_valid),
        .load_res   (dec_res),
        .free       (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = out_res.code_point;
    assign m_tuser = out_res.bad_sequence;
    assign m_tlast = out_res.string_end;

endmodule
